// ===== rtl/dcsg_pkg.sv =====
// dcsg_pkg: shared constants, types and the sine table entry function
// for the damped chirp sine generator. No dependencies.
package dcsg_pkg;

    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_BASE_STEP   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SWEEP_INIT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SWEEP_DECAY = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_AMP   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AMP_DECAY   = 3'd4;

    localparam int unsigned STEP_W   = 32;
    localparam int unsigned FRAC_W   = 32;
    localparam int unsigned SWEEP_W  = 64;
    localparam int unsigned ENV_W    = 48;
    localparam int unsigned AMP_W    = 16;
    localparam int unsigned SINE_W   = 15;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PROD_W   = AMP_W + SINE_W;

    localparam int unsigned OUT_FIFO_DEPTH = 8;
    localparam int unsigned OUT_FIFO_AW    = 3;
    localparam int unsigned OUT_FIFO_CNT_W = OUT_FIFO_AW + 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = 16'sh7fff;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        sample_t sample;
        logic    clipped;
    } out_item_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave entry k: Q2.30 Taylor series up to x^15, rounded to Q15.
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned addr_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        x    = (HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (addr_bits + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        if (sum < 0)
        begin
            sum = '0;
        end
        v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
        if (v > 64'sd32767)
        begin
            v = 64'sd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

// ===== rtl/damped_chirp_sine_generator.sv =====
// damped_chirp_sine_generator: DDS damped, swept sine source with APB config; uses dcsg_pkg.
// Pipeline: state read, state update + sine ROM, envelope multiply, output FIFO.
// Throughput: one transaction per clock while in_ready is high; the state update is a
// read-modify-write with write-back forwarding. Up to 8 transactions outstanding; in_ready
// drops at that count.
// Reset: rst_n is asynchronous; config and control clear, state reads as zero.
module damped_chirp_sine_generator #(
    parameter int unsigned SINE_ADDR_BITS = 10,
    parameter int unsigned PHASE_BITS     = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dcsg_pkg::PADDR_W-1:0]   paddr,
    input  logic [dcsg_pkg::PDATA_W-1:0]   pwdata,
    output logic [dcsg_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_ready,
    output dcsg_pkg::sample_t              sample,
    output logic                           clipped
);
    import dcsg_pkg::*;

    localparam int unsigned TABLE_SIZE = 1 << SINE_ADDR_BITS;
    localparam int unsigned K_LSB      = PHASE_BITS - SINE_ADDR_BITS - 2;

    typedef logic [SINE_W-1:0] sine_rom_t [TABLE_SIZE];

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [SWEEP_W-1:0]    sweep;
        logic [ENV_W-1:0]      env;
    } state_t;

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            rom[i] = sine_entry(i, SINE_ADDR_BITS);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // ---------------- configuration ----------------
    logic [STEP_W-1:0]    base_step_reg;
    logic [STEP_W-1:0]    sweep_init_reg;
    logic [FRAC_W-1:0]    sweep_decay_reg;
    logic [AMP_W-1:0]     start_amp_reg;
    logic [FRAC_W-1:0]    amp_decay_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_step_reg   <= '0;
            sweep_init_reg  <= '0;
            sweep_decay_reg <= '0;
            start_amp_reg   <= '0;
            amp_decay_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_BASE_STEP:   base_step_reg   <= pwdata;
                REG_SWEEP_INIT:  sweep_init_reg  <= pwdata;
                REG_SWEEP_DECAY: sweep_decay_reg <= pwdata;
                REG_START_AMP:   start_amp_reg   <= pwdata[AMP_W-1:0];
                REG_AMP_DECAY:   amp_decay_reg   <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BASE_STEP:   prdata = base_step_reg;
            REG_SWEEP_INIT:  prdata = sweep_init_reg;
            REG_SWEEP_DECAY: prdata = sweep_decay_reg;
            REG_START_AMP:   prdata = {{(PDATA_W-AMP_W){1'b0}}, start_amp_reg};
            REG_AMP_DECAY:   prdata = amp_decay_reg;
            default:         prdata = '0;
        endcase
    end

    // ---------------- transaction credit ----------------
    logic                      in_acc;
    logic                      out_acc;
    logic [OUT_FIFO_CNT_W-1:0] pend_reg;
    logic [OUT_FIFO_CNT_W-1:0] pend_next;

    assign in_ready  = (pend_reg < OUT_FIFO_CNT_W'(OUT_FIFO_DEPTH));
    assign in_acc    = in_valid & in_ready;
    assign out_acc   = out_valid & out_ready;
    assign pend_next = pend_reg + OUT_FIFO_CNT_W'(in_acc) - OUT_FIFO_CNT_W'(out_acc);

    // ---------------- state memory ----------------
    state_t state_mem [1];
    state_t rd_data_reg;
    state_t wb_reg;
    logic   state_vld_reg;
    logic   fwd_reg;
    logic   rd_clr_reg;
    logic   s1_vld_reg;
    logic   s1_restart_reg;
    state_t s1_cur;
    state_t state_next;

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            state_mem[0] <= state_next;
            wb_reg       <= state_next;
        end
        if (in_acc)
        begin
            rd_data_reg    <= state_mem[0];
            s1_restart_reg <= restart;
        end
    end

    // ---------------- stage 1: state update ----------------
    logic                      sw_neg;
    logic [SWEEP_W-1:0]        sw_mag;
    logic [STEP_W-1:0]         ipart;
    logic [STEP_W-1:0]         step;
    logic [PHASE_BITS-1:0]     phase_new;
    logic [SWEEP_W-1:0]        sw_hi_prod;
    logic [SWEEP_W-1:0]        sw_lo_prod;
    logic [SWEEP_W-1:0]        sw_mag_next;
    logic [ENV_W-1:0]          env_hi_prod;
    logic [SWEEP_W-1:0]        env_lo_prod;
    logic [1:0]                quad;
    logic [SINE_ADDR_BITS-1:0] k_raw;
    logic [SINE_ADDR_BITS-1:0] rom_addr;

    always_comb
    begin
        s1_cur = fwd_reg ? wb_reg : (rd_clr_reg ? '0 : rd_data_reg);
        if (s1_restart_reg)
        begin
            s1_cur.phase = '0;
            s1_cur.sweep = {sweep_init_reg, {FRAC_W{1'b0}}};
            s1_cur.env   = {start_amp_reg, {FRAC_W{1'b0}}};
        end
    end

    assign sw_neg    = s1_cur.sweep[SWEEP_W-1];
    assign sw_mag    = sw_neg ? (SWEEP_W'(0) - s1_cur.sweep) : s1_cur.sweep;
    assign ipart     = sw_neg ? (STEP_W'(0) - sw_mag[SWEEP_W-1:FRAC_W])
                              : sw_mag[SWEEP_W-1:FRAC_W];
    assign step      = base_step_reg + ipart;
    assign phase_new = s1_cur.phase + step[PHASE_BITS-1:0];

    assign sw_hi_prod  = SWEEP_W'(sw_mag[SWEEP_W-1:FRAC_W]) * SWEEP_W'(sweep_decay_reg);
    assign sw_lo_prod  = SWEEP_W'(sw_mag[FRAC_W-1:0]) * SWEEP_W'(sweep_decay_reg);
    assign sw_mag_next = sw_hi_prod + SWEEP_W'(sw_lo_prod[SWEEP_W-1:FRAC_W]);
    assign env_hi_prod = ENV_W'(s1_cur.env[ENV_W-1:FRAC_W]) * ENV_W'(amp_decay_reg);
    assign env_lo_prod = SWEEP_W'(s1_cur.env[FRAC_W-1:0]) * SWEEP_W'(amp_decay_reg);

    always_comb
    begin
        state_next.phase = phase_new;
        state_next.sweep = sw_neg ? (SWEEP_W'(0) - sw_mag_next) : sw_mag_next;
        state_next.env   = env_hi_prod + ENV_W'(env_lo_prod[SWEEP_W-1:FRAC_W]);
    end

    assign quad     = phase_new[PHASE_BITS-1 -: 2];
    assign k_raw    = phase_new[K_LSB +: SINE_ADDR_BITS];
    assign rom_addr = quad[0] ? ~k_raw : k_raw;

    // ---------------- stage 2: sine ROM, envelope multiply ----------------
    logic [SINE_W-1:0] rom_q_reg;
    logic [AMP_W-1:0]  s2_amp_reg;
    logic              s2_neg_reg;
    logic              s2_vld_reg;
    logic [PROD_W-1:0] s3_prod_reg;
    logic              s3_neg_reg;
    logic              s3_vld_reg;

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            rom_q_reg  <= SINE_ROM[rom_addr];
            s2_amp_reg <= s1_cur.env[ENV_W-1:FRAC_W];
            s2_neg_reg <= quad[1];
        end
        if (s2_vld_reg)
        begin
            s3_prod_reg <= PROD_W'(s2_amp_reg) * PROD_W'(rom_q_reg);
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    // ---------------- stage 3: shift, sign, saturate ----------------
    logic [SAMPLE_W-1:0] mag_y;
    out_item_t           s3_item;

    assign mag_y = s3_prod_reg[PROD_W-1 -: SAMPLE_W];

    always_comb
    begin
        if (s3_neg_reg)
        begin
            s3_item.clipped = (mag_y > 16'd32768);
            s3_item.sample  = s3_item.clipped ? SAMPLE_MIN : sample_t'(16'd0 - mag_y);
        end
        else
        begin
            s3_item.clipped = mag_y[SAMPLE_W-1];
            s3_item.sample  = s3_item.clipped ? SAMPLE_MAX : sample_t'(mag_y);
        end
    end

    // ---------------- output FIFO ----------------
    out_item_t                 fifo_mem [OUT_FIFO_DEPTH];
    logic [OUT_FIFO_AW-1:0]    wr_ptr_reg;
    logic [OUT_FIFO_AW-1:0]    rd_ptr_reg;
    logic [OUT_FIFO_CNT_W-1:0] fifo_cnt_reg;
    out_item_t                 out_item;

    always_ff @(posedge clk)
    begin
        if (s3_vld_reg)
        begin
            fifo_mem[wr_ptr_reg] <= s3_item;
        end
    end

    assign out_item  = fifo_mem[rd_ptr_reg];
    assign out_valid = (fifo_cnt_reg != '0);
    assign sample    = out_item.sample;
    assign clipped   = out_item.clipped;

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            state_vld_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            rd_clr_reg    <= 1'b1;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fifo_cnt_reg  <= '0;
        end
        else
        begin
            pend_reg   <= pend_next;
            s1_vld_reg <= in_acc;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            if (s1_vld_reg)
            begin
                state_vld_reg <= 1'b1;
            end
            if (in_acc)
            begin
                fwd_reg    <= s1_vld_reg;
                rd_clr_reg <= !state_vld_reg;
            end
            if (s3_vld_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_FIFO_AW'(1);
            end
            if (out_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + OUT_FIFO_CNT_W'(s3_vld_reg)
                            - OUT_FIFO_CNT_W'(out_acc);
        end
    end

endmodule

// ===== rtl/dcsg_checker.sv =====
// dcsg_checker: port-level assertions for damped_chirp_sine_generator,
// bound to the top level. Depends on dcsg_pkg.
module dcsg_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         psel,
    input logic                         pwrite,
    input logic [dcsg_pkg::PADDR_W-1:0] paddr,
    input logic [dcsg_pkg::PDATA_W-1:0] prdata,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input dcsg_pkg::sample_t            sample,
    input logic                         clipped
);
    import dcsg_pkg::*;

    logic [OUT_FIFO_CNT_W-1:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + OUT_FIFO_CNT_W'(in_valid & in_ready)
                        - OUT_FIFO_CNT_W'(out_valid & out_ready);
        end
    end

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> sample == SAMPLE_MAX || sample == SAMPLE_MIN)
        else $error("clipped transaction not at a rail");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(clipped))
        else $error("stalled output transaction changed");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("output transaction without a pending input");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == OUT_FIFO_CNT_W'(OUT_FIFO_DEPTH) |-> !in_ready)
        else $error("input accepted beyond outstanding limit");

    a_amp_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && paddr[PADDR_W-1:2] == REG_START_AMP
        |-> prdata[PDATA_W-1:AMP_W] == '0)
        else $error("start amplitude readback has upper bits set");

endmodule

bind damped_chirp_sine_generator dcsg_checker u_dcsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .prdata    (prdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .clipped   (clipped)
);

// ===== test/damped_chirp_sine_generator_tb.sv =====
// Self-checking testbench for damped_chirp_sine_generator: drives APB setup and
// restart transactions, predicts every sample in a scoreboard class and checks it.
// Depends on dcsg_pkg and the damped_chirp_sine_generator RTL.

class dds_sample_tracker;
    localparam int unsigned ADDR_BITS = 10;
    localparam int unsigned QUARTER_SIZE = 1 << ADDR_BITS;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

    logic [31:0] base_step;
    logic [31:0] sweep_init;
    logic [31:0] sweep_decay;
    logic [15:0] start_amp;
    logic [31:0] amp_decay;

    logic [31:0] phase;
    logic [63:0] sweep;
    logic [47:0] env;

    logic [14:0] quarter_sine [QUARTER_SIZE];
    dcsg_pkg::out_item_t samples_due [$];

    int unsigned errors;
    int unsigned checked;
    int unsigned restarts;
    int unsigned clips;

    function new();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        longint v;
        for (int k = 0; k < QUARTER_SIZE; k++)
        begin
            x = (QUARTER_TURN_Q30 * longint'(2 * k + 1)) >> (ADDR_BITS + 1);
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (sum * 32767 + (longint'(1) << 29)) >>> 30;
            if (v > 32767)
            begin
                v = 32767;
            end
            quarter_sine[k] = v[14:0];
        end
        base_step = '0;
        sweep_init = '0;
        sweep_decay = '0;
        start_amp = '0;
        amp_decay = '0;
        phase = '0;
        sweep = '0;
        env = '0;
        errors = 0;
        checked = 0;
        restarts = 0;
        clips = 0;
    endfunction

    function void write_reg(logic [dcsg_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            dcsg_pkg::REG_BASE_STEP:   base_step = value;
            dcsg_pkg::REG_SWEEP_INIT:  sweep_init = value;
            dcsg_pkg::REG_SWEEP_DECAY: sweep_decay = value;
            dcsg_pkg::REG_START_AMP:   start_amp = value[15:0];
            dcsg_pkg::REG_AMP_DECAY:   amp_decay = value;
            default: ;
        endcase
    endfunction

    // floor(m * d / 2^32)
    function logic [63:0] scale_q32(logic [63:0] m, logic [31:0] d);
        logic [63:0] hi_part;
        logic [63:0] lo_part;
        hi_part = 64'(m[63:32]) * 64'(d);
        lo_part = (64'(m[31:0]) * 64'(d)) >> 32;
        return hi_part + lo_part;
    endfunction

    function void note_tick(bit do_restart);
        logic neg;
        logic [63:0] mag;
        logic [63:0] scaled;
        logic [31:0] ipart;
        logic [11:0] top;
        logic [9:0] k;
        int s;
        longint y;
        dcsg_pkg::out_item_t item;
        if (do_restart)
        begin
            phase = '0;
            sweep = {sweep_init, 32'h0};
            env = {start_amp, 32'h0};
            restarts++;
        end
        neg = sweep[63];
        mag = neg ? (64'h0 - sweep) : sweep;
        ipart = mag[63:32];
        if (neg)
        begin
            ipart = 32'h0 - ipart;
        end
        phase = phase + base_step + ipart;

        top = phase[31:20];
        k = top[9:0];
        if (top[10])
        begin
            k = ~k;
        end
        s = int'(quarter_sine[k]);
        if (top[11])
        begin
            s = -s;
        end

        y = longint'(env[47:32]) * longint'(s < 0 ? -s : s);
        y = y >>> 15;
        if (s < 0)
        begin
            y = -y;
        end
        item.clipped = 1'b0;
        if (y > 32767)
        begin
            y = 32767;
            item.clipped = 1'b1;
        end
        if (y < -32768)
        begin
            y = -32768;
            item.clipped = 1'b1;
        end
        item.sample = y[15:0];
        if (item.clipped)
        begin
            clips++;
        end
        samples_due.push_back(item);

        scaled = scale_q32({16'h0, env}, amp_decay);
        env = scaled[47:0];
        mag = scale_q32(mag, sweep_decay);
        sweep = neg ? (64'h0 - mag) : mag;
    endfunction

    function void check_sample(dcsg_pkg::sample_t got_sample, logic got_clipped);
        dcsg_pkg::out_item_t want;
        if (samples_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected sample %0d clipped %0b", $time, got_sample, got_clipped);
            return;
        end
        want = samples_due.pop_front();
        checked++;
        if (got_sample !== want.sample)
        begin
            errors++;
            $display("%0t: sample error, expected %0d actual %0d", $time, want.sample, got_sample);
        end
        if (got_clipped !== want.clipped)
        begin
            errors++;
            $display("%0t: clipped error, expected %0b actual %0b", $time, want.clipped,
                     got_clipped);
        end
    endfunction
endclass

module damped_chirp_sine_generator_tb;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned LIMIT_CYCLES = 800_000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 125;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [dcsg_pkg::PADDR_W-1:0] paddr = '0;
    logic [dcsg_pkg::PDATA_W-1:0] pwdata = '0;
    logic [dcsg_pkg::PDATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic restart = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    dcsg_pkg::sample_t sample;
    logic clipped;

    dds_sample_tracker tracker;
    int unsigned settings_used = 0;

    damped_chirp_sine_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .clipped   (clipped)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("timeout");
        $display("damped_chirp_sine_generator: mismatch");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 9)
        begin
            return 0;
        end
        else if (r < 13)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 15)
        begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_sweep();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'($urandom_range(0, 1 << 16)) - 32'h8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_decay();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3: return 32'hFF00_0000 | ($urandom & 32'h00FF_FFFF);
            default: return 32'hFFF0_0000 | ($urandom & 32'h000F_FFFF);
        endcase
    endfunction

    function automatic logic [31:0] pick_amp();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'h0000_FFFF;
            2: return $urandom_range(0, 32767);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_sample(sample, clipped);
        end
    end

    // Result side: ready bursts, mostly short stalls, now and then a long one.
    initial
    begin
        int unsigned run_len;
        int unsigned stall_len;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            out_ready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
            repeat (run_len - 1) @(negedge clk);
            stall_len = pick_gap();
            if (stall_len > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall_len - 1) @(negedge clk);
            end
        end
    end

    task automatic write_reg(logic [dcsg_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.write_reg(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_tick(bit do_restart, int unsigned gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            restart <= 1'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        restart <= do_restart;
        do @(posedge clk); while (!in_ready);
        tracker.note_tick(do_restart);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        restart <= 1'($urandom);
        while (tracker.samples_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [31:0] step, logic [31:0] sweep0, logic [31:0] sdecay,
                             logic [31:0] amp, logic [31:0] adecay);
        settle();
        write_reg(dcsg_pkg::REG_BASE_STEP, step);
        write_reg(dcsg_pkg::REG_SWEEP_INIT, sweep0);
        write_reg(dcsg_pkg::REG_SWEEP_DECAY, sdecay);
        write_reg(dcsg_pkg::REG_START_AMP, amp);
        write_reg(dcsg_pkg::REG_AMP_DECAY, adecay);
        settings_used++;
    endtask

    initial
    begin
        bit no_gaps;
        bit do_restart;
        tracker = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // state straight out of reset, with and without restart
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);

        // full-scale extremes, clipping; unmapped register writes must be dropped
        configure(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
        for (int unsigned idx = dcsg_pkg::REG_AMP_DECAY + 1; idx < (1 << dcsg_pkg::REG_IDX_W);
             idx++)
        begin
            write_reg(idx[dcsg_pkg::REG_IDX_W-1:0], 32'h0);
        end
        send_tick(1'b1, 0);
        repeat (5) send_tick(1'b0, pick_gap());

        // most negative sweep, envelope killed after one tick
        configure(32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0);
        send_tick(1'b1, 0);
        repeat (3) send_tick(1'b0, 0);
        send_tick(1'b1, 1);
        send_tick(1'b0, 0);

        // unit envelope stepping a quarter turn: every quadrant, no clipping
        configure(32'h4000_0000, 32'h0, 32'h0, 32'h0000_8000, 32'hFFFF_FFFF);
        send_tick(1'b1, 0);
        repeat (4) send_tick(1'b0, 0);

        // zero amplitude, sweep of minus one
        configure(32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
        send_tick(1'b1, 0);
        repeat (2) send_tick(1'b0, pick_gap());

        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            configure(pick_step(), pick_sweep(), pick_decay(), pick_amp(), pick_decay());
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == 0)
                begin
                    do_restart = ($urandom_range(0, 7) != 0);
                end
                else
                begin
                    do_restart = ($urandom_range(0, 31) == 0);
                end
                send_tick(do_restart, no_gaps ? 0 : pick_gap());
            end
        end

        settle();
        $display("checked %0d samples: %0d restarts, %0d clipped, %0d register settings",
                 tracker.checked, tracker.restarts, tracker.clips, settings_used);
        if (tracker.errors == 0)
        begin
            $display("damped_chirp_sine_generator: match");
        end
        else
        begin
            $display("damped_chirp_sine_generator: mismatch");
        end
        $finish;
    end
endmodule
